// ===== hdl/lcdseq_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdseq_pkg
// Shared types and constants for the character LCD nibble sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdseq_pkg;

  // request kinds
  localparam logic [1:0] CMD_BYTE = 2'd0;
  localparam logic [1:0] CMD_DATA = 2'd1;
  localparam logic [1:0] CMD_GOTO = 2'd2;
  localparam logic [1:0] CMD_INIT = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_BASE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_BASE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3_BASE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW4_BASE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DISP_TYPE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DISP_ON    = 3'd5;

  // timing in microseconds
  localparam logic [15:0] PH_SHORT_US   = 16'd1;
  localparam logic [15:0] PH_LONG_US    = 16'd100;
  localparam logic [15:0] SLOW_CMD_US   = 16'd2000;
  localparam logic [15:0] POWERUP_US    = 16'd40000;
  localparam logic [15:0] SHORT_WAIT_US = 16'd5000;
  localparam logic [15:0] LONG_WAIT_US  = 16'd50000;

  // command bytes with the long execution time
  localparam logic [7:0] LCD_CLS   = 8'h01;
  localparam logic [7:0] LCD_HOME  = 8'h02;

  // byte queue depth
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // one byte transfer (or the power-up event) handed from front to back
  typedef struct packed {
    logic        powerup;
    logic        rs;
    logic [7:0]  code;
    logic [15:0] extra;
    logic        last;
  } byte_op_t;

endpackage

`default_nettype wire

// ===== hdl/lcdseq_front.sv =====
// ----------------------------------------------------------------------------
// lcdseq_front
// Accepts requests, holds the configuration and turns each request into
// byte transfers for the byte queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdseq_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [1:0]                    command,
  input  wire logic [7:0]                    value,
  input  wire logic [2:0]                    row,
  input  wire logic [7:0]                    column,
  input  wire logic                          cfg_write,
  input  wire logic [lcdseq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                    cfg_data,
  input  wire logic                          q_full,
  output logic                               q_push,
  output lcdseq_pkg::byte_op_t               q_op
);
  import lcdseq_pkg::*;

  logic [7:0] row1_base;
  logic [7:0] row2_base;
  logic [7:0] row3_base;
  logic [7:0] row4_base;
  logic [1:0] display_type;
  logic [7:0] display_on_code;

  logic       busy;
  logic [2:0] idx;
  logic       accept;
  logic [7:0] base;
  logic [7:0] addr;
  logic [7:0] init_code;
  logic [15:0] init_wait;

  // extra hold for clear and home
  function automatic logic [15:0] slow_extra(input logic [7:0] b);
    slow_extra = (b == LCD_CLS || b == LCD_HOME) ? SLOW_CMD_US : 16'd0;
  endfunction

  assign full   = busy | q_full;
  assign accept = push & ~full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row1_base       <= 8'd128;
      row2_base       <= 8'd192;
      row3_base       <= 8'd148;
      row4_base       <= 8'd212;
      display_type    <= 2'd2;
      display_on_code <= 8'd12;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ROW1_BASE: row1_base       <= cfg_data;
        REG_ROW2_BASE: row2_base       <= cfg_data;
        REG_ROW3_BASE: row3_base       <= cfg_data;
        REG_ROW4_BASE: row4_base       <= cfg_data;
        REG_DISP_TYPE: display_type    <= cfg_data[1:0];
        REG_DISP_ON:   display_on_code <= cfg_data;
        default: ;
      endcase
    end
  end

  // goto address from the row base
  always_comb begin
    case (row)
      3'd2:    base = row2_base;
      3'd3:    base = row3_base;
      3'd4:    base = row4_base;
      default: base = row1_base;
    endcase
    addr = base + column + 8'hFF;
  end

  // init command list
  always_comb begin
    case (idx)
      3'd0, 3'd1, 3'd2: begin
        init_code = 8'h03;
        init_wait = SHORT_WAIT_US;
      end
      3'd3: begin
        init_code = LCD_HOME;
        init_wait = SHORT_WAIT_US;
      end
      3'd4: begin
        init_code = {4'h2, display_type, 2'b00};
        init_wait = LONG_WAIT_US;
      end
      3'd5: begin
        init_code = display_on_code;
        init_wait = LONG_WAIT_US;
      end
      3'd6: begin
        init_code = LCD_CLS;
        init_wait = LONG_WAIT_US;
      end
      default: begin
        init_code = 8'h06;
        init_wait = LONG_WAIT_US;
      end
    endcase
  end

  // classify the request or step the init list
  always_comb begin
    q_push = 1'b0;
    q_op   = '0;
    if (accept) begin
      q_push = 1'b1;
      case (command)
        CMD_BYTE: begin
          q_op.code  = value;
          q_op.extra = slow_extra(value);
          q_op.last  = 1'b1;
        end
        CMD_DATA: begin
          q_op.rs   = 1'b1;
          q_op.code = value;
          q_op.last = 1'b1;
        end
        CMD_GOTO: begin
          q_op.code  = addr;
          q_op.extra = slow_extra(addr);
          q_op.last  = 1'b1;
        end
        default: begin
          q_op.powerup = 1'b1;
        end
      endcase
    end else if (busy) begin
      q_push     = ~q_full;
      q_op.code  = init_code;
      q_op.extra = init_wait + slow_extra(init_code);
      q_op.last  = (idx == 3'd7);
    end
  end

  // init sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 3'd0;
    end else if (accept && command == CMD_INIT) begin
      busy <= 1'b1;
      idx  <= 3'd0;
    end else if (busy && !q_full) begin
      idx <= idx + 3'd1;
      if (idx == 3'd7) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lcdseq_queue.sv =====
// ----------------------------------------------------------------------------
// lcdseq_queue
// Short first-in first-out queue of byte transfers between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdseq_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 wr,
  input  wire lcdseq_pkg::byte_op_t wr_op,
  output logic                      q_full,
  input  wire logic                 rd,
  output logic                      q_empty,
  output lcdseq_pkg::byte_op_t      head
);
  import lcdseq_pkg::*;

  byte_op_t             mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;
  logic                 do_wr;
  logic                 do_rd;

  assign q_full  = (count == Q_CNT_W'(Q_DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr & ~q_full;
  assign do_rd   = rd & ~q_empty;
  assign head    = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_op;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + Q_PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + Q_PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + Q_CNT_W'(1);
      end else if (!do_wr && do_rd) begin
        count <= count - Q_CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lcdseq_back.sv =====
// ----------------------------------------------------------------------------
// lcdseq_back
// Expands each byte transfer into six enable phases and holds the current
// pin event in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdseq_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 q_empty,
  input  wire lcdseq_pkg::byte_op_t head,
  output logic                      q_pop,
  output logic                      empty,
  input  wire logic                 pop,
  output logic                      reg_select,
  output logic [3:0]                data_nibble,
  output logic                      enable,
  output logic [15:0]               hold_us,
  output logic                      last
);
  import lcdseq_pkg::*;

  localparam logic [2:0] FINAL_PHASE = 3'd5;

  logic        out_valid;
  logic [2:0]  phase;
  logic        advance;
  logic        emit;
  logic        final_evt;
  logic        ev_en;
  logic        ev_long;
  logic [3:0]  ev_nib;
  logic [15:0] ev_hold;

  assign empty     = ~out_valid;
  assign advance   = ~out_valid | pop;
  assign emit      = advance & ~q_empty;
  assign final_evt = head.powerup | (phase == FINAL_PHASE);
  assign q_pop     = emit & final_evt;

  // phase decode: low, high, long low for each nibble
  always_comb begin
    case (phase)
      3'd1, 3'd4: begin
        ev_en   = 1'b1;
        ev_long = 1'b0;
      end
      3'd2, 3'd5: begin
        ev_en   = 1'b0;
        ev_long = 1'b1;
      end
      default: begin
        ev_en   = 1'b0;
        ev_long = 1'b0;
      end
    endcase
    ev_nib  = (phase < 3'd3) ? head.code[7:4] : head.code[3:0];
    ev_hold = ev_long ? PH_LONG_US + ((phase == FINAL_PHASE) ? head.extra : 16'd0)
                      : PH_SHORT_US;
  end

  // control: phase counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        phase <= final_evt ? 3'd0 : phase + 3'd1;
      end
      if (advance) begin
        out_valid <= ~q_empty;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (emit) begin
      if (head.powerup) begin
        reg_select  <= 1'b0;
        data_nibble <= 4'h0;
        enable      <= 1'b0;
        hold_us     <= POWERUP_US;
        last        <= 1'b0;
      end else begin
        reg_select  <= head.rs;
        data_nibble <= ev_nib;
        enable      <= ev_en;
        hold_us     <= ev_hold;
        last        <= head.last & (phase == FINAL_PHASE);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/char_lcd_nibble_sequencer.sv =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer
// Character LCD sequencer for a 4-bit bus: requests in, pin events out.
// ----------------------------------------------------------------------------
// A command, data or goto request yields 6 result words (two nibbles of
// three enable phases each); an init request yields 49. The back end puts
// out one word per cycle while pop is held and a byte transfer is waiting,
// all through that single event register. The front end writes byte
// transfers into a 4-deep queue and takes a new request as soon as there
// is room, so input and output stall independently; after an init request
// the input stays full while the front end feeds the init command list,
// and longer whenever the queue is full. The user must write configuration
// through cfg_write, cfg_index and cfg_data only while the block is idle;
// the block itself does not enforce it.
`default_nettype none

module char_lcd_nibble_sequencer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  command,
  input  wire logic [7:0]  value,
  input  wire logic [2:0]  row,
  input  wire logic [7:0]  column,
  input  wire logic        cfg_write,
  input  wire logic [lcdseq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]  cfg_data,
  output logic             empty,
  input  wire logic        pop,
  output logic             reg_select,
  output logic [3:0]       data_nibble,
  output logic             enable,
  output logic [15:0]      hold_us,
  output logic             last
);
  import lcdseq_pkg::*;

  logic     q_full;
  logic     q_empty;
  logic     q_push;
  logic     q_pop;
  byte_op_t q_op;
  byte_op_t q_head;

  // request front end
  lcdseq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .command   (command),
    .value     (value),
    .row       (row),
    .column    (column),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_op      (q_op)
  );

  // byte queue
  lcdseq_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_op   (q_op),
    .q_full  (q_full),
    .rd      (q_pop),
    .q_empty (q_empty),
    .head    (q_head)
  );

  // pin event back end
  lcdseq_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .head        (q_head),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .reg_select  (reg_select),
    .data_nibble (data_nibble),
    .enable      (enable),
    .hold_us     (hold_us),
    .last        (last)
  );

  // init request blocks further input while its list is fed
  a_init_blocks: assert property (@(posedge clk) disable iff (rst)
    push && !full && command == CMD_INIT |=> full)
    else $error("init request did not block input");

  // an enable-high phase is always short
  a_enable_short: assert property (@(posedge clk) disable iff (rst)
    !empty && enable |-> hold_us == PH_SHORT_US)
    else $error("enable high phase with long hold");

  // the final word of a request is a long enable-low phase
  a_last_long: assert property (@(posedge clk) disable iff (rst)
    !empty && last |-> !enable && hold_us >= PH_LONG_US)
    else $error("last word is not a long low phase");

endmodule

`default_nettype wire

// ===== verif/char_lcd_nibble_sequencer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_checker
// Watches the request, configuration and pin-event channels of the LCD
// sequencer. Every accepted request is expanded into its pin events, and each
// popped word is compared field by field with the oldest one still due.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  logic                            full,
  input  logic [1:0]                      command,
  input  logic [7:0]                      value,
  input  logic [2:0]                      row,
  input  logic [7:0]                      column,
  input  logic                            cfg_write,
  input  logic [lcdseq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                      cfg_data,
  input  logic                            empty,
  input  logic                            pop,
  input  logic                            reg_select,
  input  logic [3:0]                      data_nibble,
  input  logic                            enable,
  input  logic [15:0]                     hold_us,
  input  logic                            last,
  output int                              mismatches,
  output int                              pending,
  output int                              requests_seen,
  output int                              inits_seen,
  output int                              events_checked
);
  import lcdseq_pkg::*;

  // command bytes of the power-up list
  localparam logic [7:0] LCD_WAKE      = 8'h03;
  localparam logic [7:0] LCD_FUNC_SET  = 8'h20;
  localparam logic [7:0] LCD_ENTRY_INC = 8'h06;

  localparam int MAX_EVENTS   = 49;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic        rs;
    logic [3:0]  nibble;
    logic        en;
    logic [15:0] hold;
    logic        last;
  } pin_event_t;

  // pin events still owed by the block, oldest first
  pin_event_t pin_events_due[$];

  // events of the request being expanded
  pin_event_t request_events [MAX_EVENTS];
  int         request_len;

  // shadow of the configuration registers
  logic [7:0] row_addr [4];
  logic [1:0] func_type;
  logic [7:0] disp_on_cmd;

  task automatic emit_phase(input logic rs, input logic [3:0] nib, input logic en,
                            input logic [15:0] hold);
    request_events[request_len] = '{rs: rs, nibble: nib, en: en, hold: hold, last: 1'b0};
    request_len++;
  endtask

  // one nibble: enable low, high, then low with the long hold
  task automatic emit_nibble(input logic rs, input logic [3:0] nib, input logic [15:0] extra);
    emit_phase(rs, nib, 1'b0, PH_SHORT_US);
    emit_phase(rs, nib, 1'b1, PH_SHORT_US);
    emit_phase(rs, nib, 1'b0, PH_LONG_US + extra);
  endtask

  task automatic emit_byte(input logic rs, input logic [7:0] code, input logic [15:0] extra);
    emit_nibble(rs, code[7:4], 16'd0);
    emit_nibble(rs, code[3:0], extra);
  endtask

  // clear and home need the long execution time on top of any wait
  task automatic emit_command(input logic [7:0] code, input logic [15:0] wait_us);
    logic [15:0] extra;
    extra = wait_us;
    if (code == LCD_CLS || code == LCD_HOME) begin
      extra = extra + SLOW_CMD_US;
    end
    emit_byte(1'b0, code, extra);
  endtask

  task automatic expand_request(input logic [1:0] kind, input logic [7:0] val,
                                input logic [2:0] r, input logic [7:0] col);
    logic [7:0] base;
    logic [7:0] addr;
    request_len = 0;
    case (kind)
      CMD_BYTE: emit_command(val, 16'd0);
      CMD_DATA: emit_byte(1'b1, val, 16'd0);
      CMD_GOTO: begin
        // rows two to four have their own base, anything else is row one
        case (r)
          3'd2:    base = row_addr[1];
          3'd3:    base = row_addr[2];
          3'd4:    base = row_addr[3];
          default: base = row_addr[0];
        endcase
        addr = base + col - 8'd1;
        emit_command(addr, 16'd0);
      end
      default: begin
        // power-up sequence
        emit_phase(1'b0, 4'h0, 1'b0, POWERUP_US);
        emit_command(LCD_WAKE, SHORT_WAIT_US);
        emit_command(LCD_WAKE, SHORT_WAIT_US);
        emit_command(LCD_WAKE, SHORT_WAIT_US);
        emit_command(LCD_HOME, SHORT_WAIT_US);
        emit_command(LCD_FUNC_SET | {4'h0, func_type, 2'b00}, LONG_WAIT_US);
        emit_command(disp_on_cmd, LONG_WAIT_US);
        emit_command(LCD_CLS, LONG_WAIT_US);
        emit_command(LCD_ENTRY_INC, LONG_WAIT_US);
      end
    endcase
    request_events[request_len-1].last = 1'b1;
    for (int i = 0; i < request_len; i++) begin
      pin_events_due.push_back(request_events[i]);
    end
  endtask

  always @(posedge clk) begin
    pin_event_t want;
    if (rst) begin
      // register reset values
      row_addr[0] = 8'd128;
      row_addr[1] = 8'd192;
      row_addr[2] = 8'd148;
      row_addr[3] = 8'd212;
      func_type   = 2'd2;
      disp_on_cmd = 8'd12;
      pin_events_due.delete();
      mismatches     = 0;
      requests_seen  = 0;
      inits_seen     = 0;
      events_checked = 0;
    end else begin
      // configuration writes
      if (cfg_write) begin
        case (cfg_index)
          REG_ROW1_BASE: row_addr[0] = cfg_data;
          REG_ROW2_BASE: row_addr[1] = cfg_data;
          REG_ROW3_BASE: row_addr[2] = cfg_data;
          REG_ROW4_BASE: row_addr[3] = cfg_data;
          REG_DISP_TYPE: func_type   = cfg_data[1:0];
          REG_DISP_ON:   disp_on_cmd = cfg_data;
          default: ;
        endcase
      end

      // accepted request word
      if (push && !full) begin
        expand_request(command, value, row, column);
        requests_seen++;
        if (command == CMD_INIT) begin
          inits_seen++;
        end
      end

      // accepted pin-event word
      if (pop && !empty) begin
        if (pin_events_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: unexpected pin event rs=%0d d=%h en=%0d hold=%0d last=%0d",
                     $time, reg_select, data_nibble, enable, hold_us, last);
          end
        end else begin
          want = pin_events_due.pop_front();
          events_checked++;
          if (want.rs !== reg_select || want.nibble !== data_nibble || want.en !== enable ||
              want.hold !== hold_us || want.last !== last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("%0t: pin event %0d mismatch: expected rs=%0d d=%h en=%0d hold=%0d last=%0d",
                       $time, events_checked, want.rs, want.nibble, want.en, want.hold,
                       want.last);
              $display("%0t:   got rs=%0d d=%h en=%0d hold=%0d last=%0d",
                       $time, reg_select, data_nibble, enable, hold_us, last);
            end
          end
        end
      end
    end
    pending = pin_events_due.size();
  end

endmodule

// ===== verif/char_lcd_nibble_sequencer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_tb
// Drives requests into the LCD sequencer in random bursts while the output
// side pops on changing patterns, including one long hold-off that fills the
// block. Runs a directed set, then random requests under several register
// settings; the checker beside the block does all the comparing.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer_tb;
  import lcdseq_pkg::*;

  localparam int CYCLE_LIMIT       = 400_000;
  localparam int RESET_CYCLES      = 10;
  localparam int SETTLE_CYCLES     = 20;
  localparam int LONG_STALL_CYCLES = 400;
  localparam int PHASE_ITEMS       = 25;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef enum logic [1:0] {POP_ALWAYS, POP_RANDOM, POP_SPARSE, POP_PATTERN} pop_mode_e;

  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 push        = 1'b0;
  logic                 full;
  logic [1:0]           command     = CMD_BYTE;
  logic [7:0]           value       = 8'd0;
  logic [2:0]           row         = 3'd0;
  logic [7:0]           column      = 8'd0;
  logic                 cfg_write   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = REG_ROW1_BASE;
  logic [7:0]           cfg_data    = 8'd0;
  logic                 empty;
  logic                 pop         = 1'b0;
  logic                 reg_select;
  logic [3:0]           data_nibble;
  logic                 enable;
  logic [15:0]          hold_us;
  logic                 last;

  int mismatches;
  int pending;
  int requests_seen;
  int inits_seen;
  int events_checked;

  int starve_asked     = 0;
  int starve_done      = 0;
  int burst_left       = 0;
  bit eager            = 1'b0;
  int settings_applied = 1;
  int cycle_count      = 0;

  char_lcd_nibble_sequencer dut (.*);

  char_lcd_nibble_sequencer_checker pin_check (.*);

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d pin events still awaited", cycle_count, pending);
    $display("FAIL");
    $finish;
  end

  // output side: pop on a changing pattern, with a long hold-off on request
  initial begin
    pop_mode_e  mode;
    int         mode_left;
    logic [7:0] pattern;
    mode_left = 0;
    pattern   = 8'd0;
    mode      = POP_ALWAYS;
    do @(posedge clk); while (rst);
    forever begin
      if (starve_done != starve_asked) begin
        pop <= 1'b0;
        for (int n = 0; n < LONG_STALL_CYCLES; n++) begin
          @(posedge clk);
        end
        starve_done++;
      end else begin
        if (mode_left == 0) begin
          mode      = pop_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 150);
          pattern   = 8'($urandom);
        end
        case (mode)
          POP_ALWAYS: pop <= 1'b1;
          POP_RANDOM: pop <= 1'($urandom_range(0, 1));
          POP_SPARSE: pop <= ($urandom_range(0, 3) == 0);
          POP_PATTERN: begin
            pop     <= pattern[0];
            pattern  = {pattern[0], pattern[7:1]};
          end
        endcase
        mode_left--;
        @(posedge clk);
      end
    end
  end

  // offer one request word, opening a new burst after a random gap
  task automatic offer(input logic [1:0] kind, input logic [7:0] val, input logic [2:0] r,
                       input logic [7:0] col);
    int gap;
    if (burst_left == 0) begin
      gap = (eager || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 6);
    end
    command <= kind;
    value   <= val;
    row     <= r;
    column  <= col;
    push    <= 1'b1;
    do @(posedge clk); while (full);
    burst_left--;
  endtask

  // random request mix, leaning towards clear/home and edge columns now and then
  task automatic offer_random();
    int         pick;
    logic [1:0] kind;
    logic [7:0] val;
    logic [7:0] col;
    logic [2:0] r;
    pick = $urandom_range(0, 99);
    kind = (pick < 10) ? CMD_INIT : (pick < 40) ? CMD_GOTO : (pick < 70) ? CMD_BYTE : CMD_DATA;
    val  = 8'($urandom);
    if (kind == CMD_BYTE && $urandom_range(0, 5) == 0) begin
      val = $urandom_range(0, 1) ? LCD_CLS : LCD_HOME;
    end
    r   = 3'($urandom);
    col = 8'($urandom);
    if ($urandom_range(0, 7) == 0) begin
      col = $urandom_range(0, 1) ? 8'd0 : 8'd255;
    end
    offer(kind, val, r, col);
  endtask

  // wait until every pin event has come out and the block has settled
  task automatic wait_idle();
    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  // write all registers, spare indexes last, junk above the type bits
  task automatic apply_settings(input logic [7:0] r1, input logic [7:0] r2,
                                input logic [7:0] r3, input logic [7:0] r4,
                                input logic [1:0] dtype, input logic [7:0] on_code);
    logic [7:0] reg_data [8];
    logic [5:0] junk;
    junk = 6'($urandom);
    reg_data[REG_ROW1_BASE] = r1;
    reg_data[REG_ROW2_BASE] = r2;
    reg_data[REG_ROW3_BASE] = r3;
    reg_data[REG_ROW4_BASE] = r4;
    reg_data[REG_DISP_TYPE] = {junk, dtype};
    reg_data[REG_DISP_ON]   = on_code;
    reg_data[REG_SPARE_A]   = 8'($urandom);
    reg_data[REG_SPARE_B]   = 8'($urandom);
    for (int i = 0; i < 8; i++) begin
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= reg_data[i];
      cfg_write <= 1'b1;
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    settings_applied++;
  endtask

  task automatic random_phase();
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      offer_random();
    end
    wait_idle();
  endtask

  // stimulus
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed: byte extremes, clear and home, data extremes
    offer(CMD_BYTE, 8'h00, 3'($urandom), 8'($urandom));
    offer(CMD_BYTE, 8'hFF, 3'($urandom), 8'($urandom));
    offer(CMD_BYTE, LCD_CLS, 3'($urandom), 8'($urandom));
    offer(CMD_BYTE, LCD_HOME, 3'($urandom), 8'($urandom));
    offer(CMD_BYTE, 8'h03, 3'($urandom), 8'($urandom));
    offer(CMD_DATA, 8'h00, 3'($urandom), 8'($urandom));
    offer(CMD_DATA, 8'hFF, 3'($urandom), 8'($urandom));
    offer(CMD_DATA, 8'hA5, 3'($urandom), 8'($urandom));
    offer(CMD_DATA, 8'h5A, 3'($urandom), 8'($urandom));
    // every row, column zero and 255, addresses landing on clear and home
    offer(CMD_GOTO, 8'($urandom), 3'd0, 8'd1);
    offer(CMD_GOTO, 8'($urandom), 3'd1, 8'd255);
    offer(CMD_GOTO, 8'($urandom), 3'd2, 8'd0);
    offer(CMD_GOTO, 8'($urandom), 3'd3, 8'd1);
    offer(CMD_GOTO, 8'($urandom), 3'd4, 8'd44);
    offer(CMD_GOTO, 8'($urandom), 3'd5, 8'd130);
    offer(CMD_GOTO, 8'($urandom), 3'd6, 8'd131);
    offer(CMD_GOTO, 8'($urandom), 3'd7, 8'd128);
    // power-up sequence, with junk in every ignored field
    offer(CMD_INIT, 8'($urandom), 3'($urandom), 8'($urandom));
    offer(CMD_INIT, 8'($urandom), 3'($urandom), 8'($urandom));
    wait_idle();

    // all registers at the bottom, display-on code equal to clear
    apply_settings(8'd0, 8'd0, 8'd0, 8'd0, 2'd0, LCD_CLS);
    random_phase();

    // all registers at the top, display-on code equal to home, long hold-off
    apply_settings(8'd255, 8'd255, 8'd255, 8'd255, 2'd3, LCD_HOME);
    starve_asked++;
    random_phase();

    // random settings, sender without gaps
    apply_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 2'($urandom),
                   8'($urandom));
    eager = 1'b1;
    random_phase();

    // random settings, bursty sender again
    apply_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 2'($urandom),
                   8'($urandom));
    eager = 1'b0;
    random_phase();

    $display("covered %0d requests (%0d power-up sequences) under %0d register settings",
             requests_seen, inits_seen, settings_applied);
    $display("%0d pin events checked, %0d long output hold-off(s), %0d mismatches",
             events_checked, starve_done, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
